// ===== sv/gtama_pkg.sv =====
// ----------------------------------------------------------------------------
// gtama_pkg
// Shared types and constants for the gated three-axis moving average unit.
// ----------------------------------------------------------------------------
package gtama_pkg;

	localparam int WINDOW   = 10;
	localparam int AXES     = 3;

	localparam int SPEED_W  = 16;
	localparam int GYRO_W   = 24;
	localparam int LIMIT_W  = 15;
	localparam int MODE_W   = 8;
	localparam int WARM_W   = 5;
	localparam int CFG_W    = 15;
	localparam int CFG_IX_W = 2;

	localparam int SAMPLE_W = GYRO_W;
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

	localparam int RECIP_SH = 32;
	localparam logic [RECIP_SH-1:0] RECIP =
		RECIP_SH'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12800);
	localparam logic [MODE_W-1:0]  SAFE_RESET  = '0;
	localparam logic [WARM_W-1:0]  WARM_RESET  = WARM_W'(20);
	localparam logic [MODE_W-1:0]  MODE_NONE   = MODE_W'(255);

	typedef enum logic [CFG_IX_W-1:0] {
		REG_SPEED_LIMIT = 2'd0,
		REG_SAFE_MODE   = 2'd1,
		REG_WARM_TICKS  = 2'd2
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [SAMPLE_W-1:0]        quot_t;

	typedef struct packed {
		logic                             wv;
		logic                             gv;
		logic                             turn_on;
		logic [AXES-1:0][SPEED_W-1:0]     latest;
	} flags_t;

endpackage

// ===== sv/gtama_lane.sv =====
// ----------------------------------------------------------------------------
// gtama_lane
// One axis window: shift line of samples and a running sum over it.
// ----------------------------------------------------------------------------
module gtama_lane
	import gtama_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    store,
	input  sample_t sample,
	output sum_t    sum,
	output sample_t latest
);

	sample_t line_q [WINDOW];
	sum_t    sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				line_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (store) begin
			line_q[0] <= sample;
			for (int i = 1; i < WINDOW; i++) begin
				line_q[i] <= line_q[i-1];
			end
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(line_q[WINDOW-1]);
		end
	end

	assign sum    = sum_q;
	assign latest = line_q[0];

endmodule

// ===== sv/gtama_mean.sv =====
// ----------------------------------------------------------------------------
// gtama_mean
// Window mean truncated toward zero: reciprocal multiply, then sign restore.
// ----------------------------------------------------------------------------
module gtama_mean
	import gtama_pkg::*;
(
	input  logic    clk,
	input  logic    en_s2,
	input  logic    en_out,
	input  sum_t    sum,
	output sample_t avg
);

	logic [SUM_W-1:0]          mag;
	logic [SUM_W+RECIP_SH-1:0] prod;
	quot_t                     quot_s2;
	logic                      neg_s2;
	sample_t                   avg_q;

	assign mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign prod = (SUM_W+RECIP_SH)'(mag) * (SUM_W+RECIP_SH)'(RECIP);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			quot_s2 <= prod[RECIP_SH +: SAMPLE_W];
			neg_s2  <= sum[SUM_W-1];
		end
		if (en_out) begin
			avg_q <= neg_s2 ? -$signed(quot_s2) : $signed(quot_s2);
		end
	end

	assign avg = avg_q;

endmodule

// ===== sv/gated_three_axis_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// gated_three_axis_moving_average_unit
// Warm-up gating, speed gate and six parallel window lanes with a merge stage.
// ----------------------------------------------------------------------------
// Accepted items pass three register stages (v_s1, v_s2, out_valid_q) to out_valid.
// One item per cycle unless out_stall holds the pipe; lane sums update at acceptance.
// The mean path is a reciprocal multiply stage followed by a sign stage.
// Reset clears windows, sums, pipeline valids and loads register defaults
// asynchronously; no clearing pass.
module gated_three_axis_moving_average_unit
	import gtama_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_we,
	input  logic [CFG_IX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [SPEED_W-1:0] wheel_speed_0,
	input  logic signed [SPEED_W-1:0] wheel_speed_1,
	input  logic signed [SPEED_W-1:0] wheel_speed_2,
	input  logic signed [GYRO_W-1:0]  gyro_rate_x,
	input  logic signed [GYRO_W-1:0]  gyro_rate_y,
	input  logic signed [GYRO_W-1:0]  gyro_rate_z,
	input  logic                      gyro_ok,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      wheel_avg_valid,
	output logic signed [SPEED_W-1:0] wheel_avg_0,
	output logic signed [SPEED_W-1:0] wheel_avg_1,
	output logic signed [SPEED_W-1:0] wheel_avg_2,
	output logic                      gyro_avg_valid,
	output logic signed [GYRO_W-1:0]  gyro_avg_x,
	output logic signed [GYRO_W-1:0]  gyro_avg_y,
	output logic signed [GYRO_W-1:0]  gyro_avg_z,
	output logic                      wheels_turn_on,
	output logic signed [SPEED_W-1:0] latest_speed_0,
	output logic signed [SPEED_W-1:0] latest_speed_1,
	output logic signed [SPEED_W-1:0] latest_speed_2
);

	logic [LIMIT_W-1:0] speed_limit_q;
	logic [MODE_W-1:0]  safe_mode_q;
	logic [WARM_W-1:0]  warm_ticks_q;
	logic [WARM_W-1:0]  warm_left_q;
	logic [MODE_W-1:0]  last_mode_q;

	logic v_s1, v_s2, out_valid_q;
	logic out_rdy, rdy2, rdy1, accept;
	logic en_s2, en_out;

	logic [WARM_W-1:0]  warm_eff;
	logic               mode_chg, is_hk, warm;
	logic               store_spd, store_gyr;
	logic signed [LIMIT_W+1:0] lim_s;

	logic signed [SPEED_W-1:0] wheel_in [AXES];
	logic signed [GYRO_W-1:0]  gyro_in  [AXES];
	sample_t spd_sample [AXES];
	sample_t gyr_sample [AXES];
	sum_t    spd_sum    [AXES];
	sum_t    gyr_sum    [AXES];
	sample_t spd_latest [AXES];
	sample_t gyr_latest [AXES];
	sample_t spd_avg    [AXES];
	sample_t gyr_avg    [AXES];

	flags_t fl_in, fl_s1, fl_s2, fl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= LIMIT_RESET;
			safe_mode_q   <= SAFE_RESET;
			warm_ticks_q  <= WARM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_SAFE_MODE:   safe_mode_q   <= cfg_data[MODE_W-1:0];
				REG_WARM_TICKS:  warm_ticks_q  <= cfg_data[WARM_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_rdy  = !out_valid_q || !out_stall;
	assign rdy2     = !v_s2 || out_rdy;
	assign rdy1     = !v_s1 || rdy2;
	assign accept   = in_valid && rdy1;
	assign in_stall = !rdy1;
	assign en_s2    = v_s1 && rdy2;
	assign en_out   = v_s2 && out_rdy;

	assign mode_chg  = mode != last_mode_q;
	assign warm_eff  = mode_chg ? warm_ticks_q : warm_left_q;
	assign is_hk     = req_type;
	assign warm      = warm_eff == '0;
	assign store_spd = accept && !is_hk && warm;
	assign store_gyr = store_spd && (mode != safe_mode_q);
	assign lim_s     = $signed({2'b00, speed_limit_q});

	assign wheel_in[0] = wheel_speed_0;
	assign wheel_in[1] = wheel_speed_1;
	assign wheel_in[2] = wheel_speed_2;
	assign gyro_in[0]  = gyro_rate_x;
	assign gyro_in[1]  = gyro_rate_y;
	assign gyro_in[2]  = gyro_rate_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_left_q <= WARM_RESET;
			last_mode_q <= MODE_NONE;
		end else if (accept) begin
			last_mode_q <= mode;
			if (is_hk && !warm) begin
				warm_left_q <= warm_eff - WARM_W'(1);
			end else begin
				warm_left_q <= warm_eff;
			end
		end
	end

	always_comb begin
		fl_in         = '0;
		fl_in.wv      = !is_hk && warm;
		fl_in.gv      = !is_hk && warm && (mode != safe_mode_q);
		fl_in.turn_on = is_hk && (warm_eff == WARM_W'(1));
		for (int a = 0; a < AXES; a++) begin
			if (is_hk && warm) begin
				fl_in.latest[a] = spd_latest[a][SPEED_W-1:0];
			end
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		logic signed [LIMIT_W+1:0] w_ext;
		assign w_ext = (LIMIT_W+2)'(wheel_in[a]);
		assign spd_sample[a] = (w_ext > lim_s || w_ext < -lim_s) ? '0 :
			SAMPLE_W'(wheel_in[a]);
		assign gyr_sample[a] = gyro_ok ? SAMPLE_W'(gyro_in[a]) : '0;

		gtama_lane u_spd_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.store  (store_spd),
			.sample (spd_sample[a]),
			.sum    (spd_sum[a]),
			.latest (spd_latest[a])
		);

		gtama_lane u_gyr_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.store  (store_gyr),
			.sample (gyr_sample[a]),
			.sum    (gyr_sum[a]),
			.latest (gyr_latest[a])
		);

		gtama_mean u_spd_mean (
			.clk    (clk),
			.en_s2  (en_s2),
			.en_out (en_out),
			.sum    (spd_sum[a]),
			.avg    (spd_avg[a])
		);

		gtama_mean u_gyr_mean (
			.clk    (clk),
			.en_s2  (en_s2),
			.en_out (en_out),
			.sum    (gyr_sum[a]),
			.avg    (gyr_avg[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= accept;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (out_rdy) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fl_s1 <= fl_in;
		end
		if (en_s2) begin
			fl_s2 <= fl_s1;
		end
		if (en_out) begin
			fl_q <= fl_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign wheel_avg_valid = fl_q.wv;
	assign gyro_avg_valid  = fl_q.gv;
	assign wheels_turn_on  = fl_q.turn_on;
	assign wheel_avg_0     = fl_q.wv ? spd_avg[0][SPEED_W-1:0] : '0;
	assign wheel_avg_1     = fl_q.wv ? spd_avg[1][SPEED_W-1:0] : '0;
	assign wheel_avg_2     = fl_q.wv ? spd_avg[2][SPEED_W-1:0] : '0;
	assign gyro_avg_x      = fl_q.gv ? gyr_avg[0][GYRO_W-1:0] : '0;
	assign gyro_avg_y      = fl_q.gv ? gyr_avg[1][GYRO_W-1:0] : '0;
	assign gyro_avg_z      = fl_q.gv ? gyr_avg[2][GYRO_W-1:0] : '0;
	assign latest_speed_0  = fl_q.latest[0];
	assign latest_speed_1  = fl_q.latest[1];
	assign latest_speed_2  = fl_q.latest[2];

endmodule

// ===== sv/gtama_checker.sv =====
// ----------------------------------------------------------------------------
// gtama_checker
// Port-level checks on the result channel of the moving average unit.
// ----------------------------------------------------------------------------
module gtama_checker
	import gtama_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      wheel_avg_valid,
	input logic signed [SPEED_W-1:0] wheel_avg_0,
	input logic                      gyro_avg_valid,
	input logic signed [GYRO_W-1:0]  gyro_avg_x,
	input logic                      wheels_turn_on,
	input logic signed [SPEED_W-1:0] latest_speed_0,
	input logic signed [SPEED_W-1:0] latest_speed_1,
	input logic signed [SPEED_W-1:0] latest_speed_2
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(wheel_avg_0) && $stable(gyro_avg_x))
		else $error("stalled item changed");

	a_gyro_implies_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gyro_avg_valid |-> wheel_avg_valid)
		else $error("gyro means without wheel means");

	a_turn_on_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wheels_turn_on |-> !wheel_avg_valid && !gyro_avg_valid)
		else $error("turn-on pulse on an averaging item");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wheel_avg_valid |-> wheel_avg_0 == '0 && gyro_avg_x == '0)
		else $error("means not cleared on a non-averaging item");

	a_latest_hk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (latest_speed_0 != '0 || latest_speed_1 != '0 || latest_speed_2 != '0)
		|-> !wheel_avg_valid && !wheels_turn_on)
		else $error("latest speeds on a non-housekeeping item");

endmodule

bind gated_three_axis_moving_average_unit gtama_checker u_gtama_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.wheel_avg_valid (wheel_avg_valid),
	.wheel_avg_0     (wheel_avg_0),
	.gyro_avg_valid  (gyro_avg_valid),
	.gyro_avg_x      (gyro_avg_x),
	.wheels_turn_on  (wheels_turn_on),
	.latest_speed_0  (latest_speed_0),
	.latest_speed_1  (latest_speed_1),
	.latest_speed_2  (latest_speed_2)
);
